@@ hw/rtl/ff_pkg.sv @@
`default_nettype none

package ff_pkg;

  // queue geometry
  localparam int DEPTH       = 8;
  localparam int FRAME_BYTES = 64;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int FLEN_W  = 7;
  localparam int LEVEL_W = 4;

  // derived widths
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
  localparam int OFF_W  = $clog2(FRAME_BYTES + 2);
  localparam int STORE_DEPTH = DEPTH * FRAME_BYTES;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_END  = 2'd1,
    CMD_POP  = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_LONG  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_BYTE
  } fsm_state_t;

  // one result item
  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last;
    logic [FLEN_W-1:0]   frame_len;
    logic [LEVEL_W-1:0]  level;
  } res_t;

  // frame store port request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  // length table port request
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [LEN_W-1:0]  wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } len_req_t;

  // byte address of an offset within a slot
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [OFF_W-1:0] off);
    logic [ADDR_W+SLOT_W+OFF_W-1:0] full;
    full = (ADDR_W+SLOT_W+OFF_W)'(slot) * (ADDR_W+SLOT_W+OFF_W)'(FRAME_BYTES)
         + (ADDR_W+SLOT_W+OFF_W)'(off);
    return full[ADDR_W-1:0];
  endfunction

  // ring pointer advance
  function automatic logic [SLOT_W-1:0] ptr_inc(input logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] r;
    if (p == SLOT_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/frame_fifo.sv @@
`default_nettype none
// frame_fifo: ring of frame slots kept in a byte store and a length table
// push and cmd 3 give no result; end-frame gives its result from the output register in the next cycle
// pop: the length table is read first, then one byte per cycle out of the frame store port
// while the output is not stalled; an empty frame gives one result with no byte, an empty queue ST_EMPTY
// a request waits while a pop is still streaming or the output register is full and stalled
// rst_n is synchronous, active low: pointers, counts and control clear, memories keep contents

module frame_fifo
  import ff_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // in_byte[7:0]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // out_byte[7:0], frame_len[14:8], level[18:15], zero
  output      logic [2:0]  out_tuser,  // status[1:0], byte_valid[2]
  output      logic        out_tlast   // last
);

  logic             ld_ok;
  logic             res_valid;
  res_t             res;
  res_t             out_res;
  store_req_t       st_req;
  len_req_t         len_req;
  logic [BYTE_W-1:0] st_rdata;
  logic [LEN_W-1:0] len_rdata;

  // sequencer
  ff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_byte   (in_tdata),
    .ld_ok     (ld_ok),
    .res_valid (res_valid),
    .res       (res),
    .st_req    (st_req),
    .st_rdata  (st_rdata),
    .len_req   (len_req),
    .len_rdata (len_rdata)
  );

  // frame byte store
  ff_ram #(
    .WIDTH   (BYTE_W),
    .ENTRIES (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_req.we),
    .waddr (st_req.waddr),
    .wdata (st_req.wdata),
    .re    (st_req.re),
    .raddr (st_req.raddr),
    .rdata (st_rdata)
  );

  // per-slot frame lengths
  ff_ram #(
    .WIDTH   (LEN_W),
    .ENTRIES (DEPTH)
  ) u_lens (
    .clk   (clk),
    .we    (len_req.we),
    .waddr (len_req.waddr),
    .wdata (len_req.wdata),
    .re    (len_req.re),
    .raddr (len_req.raddr),
    .rdata (len_rdata)
  );

  // output register stage
  ff_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .ld_ok     (ld_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // result packing
  assign out_tdata = {5'b0, out_res.level, out_res.frame_len, out_res.out_byte};
  assign out_tuser = {out_res.byte_valid, out_res.status};
  assign out_tlast = out_res.last;

endmodule

`default_nettype wire

@@ hw/rtl/ff_ram.sv @@
`default_nettype none

module ff_ram #(
  parameter int WIDTH   = 8,
  parameter int ENTRIES = 16
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [$clog2(ENTRIES)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic                               re,
  input  wire logic [$clog2(ENTRIES)-1:0]         raddr,
  output      logic [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [ENTRIES];

  // write port and registered read, read data holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ff_ctrl.sv @@
`default_nettype none

module ff_ctrl
  import ff_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [BYTE_W-1:0]  in_byte,
  input  wire logic               ld_ok,
  output      logic               res_valid,
  output      res_t               res,
  output      store_req_t         st_req,
  input  wire logic [BYTE_W-1:0]  st_rdata,
  output      len_req_t           len_req,
  input  wire logic [LEN_W-1:0]   len_rdata
);

  fsm_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [OFF_W-1:0]  build_r, build_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [OFF_W-1:0]  idx_r, idx_nxt;

  logic              acc;
  logic [LEN_W-1:0]  len_clamp;
  logic              byte_last;

  assign in_ready  = (state_r == S_IDLE) && ld_ok;
  assign acc       = in_valid && in_ready;
  assign len_clamp = (len_rdata > LEN_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES) : len_rdata;
  assign byte_last = ((idx_r + OFF_W'(1)) == OFF_W'(len_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && (in_cmd == CMD_POP) && (count_r != '0)) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (len_clamp != '0) begin
          state_nxt = S_BYTE;
        end else if (ld_ok) begin
          state_nxt = S_IDLE;
        end
      end
      S_BYTE: begin
        if (ld_ok && byte_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory requests and results
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    build_nxt = build_r;
    slot_nxt  = slot_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    st_req    = '0;
    len_req   = '0;
    res_valid = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    res.level = LEVEL_W'(count_r);
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_cmd)
            CMD_PUSH: begin
              if (build_r < OFF_W'(FRAME_BYTES)) begin
                if (count_r < CNT_W'(DEPTH)) begin
                  st_req.we    = 1'b1;
                  st_req.waddr = slot_addr(tail_r, build_r);
                  st_req.wdata = in_byte;
                end
                build_nxt = build_r + OFF_W'(1);
              end else begin
                build_nxt = OFF_W'(FRAME_BYTES + 1);
              end
            end
            CMD_END: begin
              build_nxt = '0;
              res_valid = 1'b1;
              if (count_r >= CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
              end else if (build_r > OFF_W'(FRAME_BYTES)) begin
                res.status = ST_LONG;
              end else begin
                len_req.we    = 1'b1;
                len_req.waddr = tail_r;
                len_req.wdata = LEN_W'(build_r);
                tail_nxt      = ptr_inc(tail_r);
                count_nxt     = count_r + CNT_W'(1);
                res.status    = ST_OK;
                res.frame_len = FLEN_W'(build_r);
                res.level     = LEVEL_W'(count_r + CNT_W'(1));
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                len_req.re    = 1'b1;
                len_req.raddr = head_r;
                slot_nxt      = head_r;
                head_nxt      = ptr_inc(head_r);
                count_nxt     = count_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN: begin
        // length is back: empty frame answers at once, else fetch first byte
        if (len_clamp == '0) begin
          if (ld_ok) begin
            res_valid  = 1'b1;
            res.status = ST_OK;
          end
        end else begin
          st_req.re    = 1'b1;
          st_req.raddr = slot_addr(slot_r, '0);
          len_nxt      = len_clamp;
          idx_nxt      = '0;
        end
      end
      S_BYTE: begin
        // hand the fetched byte over and prefetch the next one
        if (ld_ok) begin
          res_valid      = 1'b1;
          res.status     = ST_OK;
          res.out_byte   = st_rdata;
          res.byte_valid = 1'b1;
          res.last       = byte_last;
          res.frame_len  = FLEN_W'(len_r);
          if (!byte_last) begin
            st_req.re    = 1'b1;
            st_req.raddr = slot_addr(slot_r, idx_r + OFF_W'(1));
            idx_nxt      = idx_r + OFF_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      build_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      build_r <= build_nxt;
    end
  end

  // pop context
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ff_out.sv @@
`default_nettype none

module ff_out
  import ff_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  res_valid,
  input  wire res_t  res,
  output      logic  ld_ok,
  output      logic  out_valid,
  input  wire logic  out_ready,
  output      res_t  out_res
);

  logic valid_r;
  res_t res_r;

  // register is free when empty or being drained
  assign ld_ok     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld_ok) begin
      valid_r <= res_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ld_ok && res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire
